[src/mrlb_pkg.sv]
package mrlb_pkg;

  // field widths
  localparam int unsigned LEN_W    = 8;
  localparam int unsigned PEN_W    = 40;
  localparam int unsigned SEEN_W   = 9;
  localparam int unsigned SQ_W     = 16;
  localparam int unsigned CUBE_W   = 24;
  // running line length: at most 255 + 255 + 1 before the fit check
  localparam int unsigned USED_W   = 9;

  localparam logic [PEN_W-1:0] PENALTY_MAX    = {PEN_W{1'b1}};
  localparam logic [LEN_W-1:0] LINE_WIDTH_RST = 8'd80;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // store an incoming word
    logic init_i;    // start the search at the last stored word
    logic row_init;  // open a new start position
    logic acc;       // add the next word to the candidate line
    logic sq;        // square the slack
    logic cube;      // cube the slack
    logic add;       // add the suffix cost
    logic cmp;       // keep the smaller cost, move to next end position
    logic fin;       // close the start position
  } mrlb_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic brk;       // candidate line no longer fits
    logic j_last;    // candidate line ends at the final word
    logic i_zero;    // start position is the first word
    logic any;       // at least one line fits at this start position
  } mrlb_stat_t;

endpackage

[src/min_raggedness_line_break_top.sv]
// channel   | handshake                   | payload
// ----------+-----------------------------+---------------------------------------------
// word in   | start_i, busy_o             | word_length_i, last_word_i
// config    | line_width_we_i             | line_width_i
// result    | done_o (one-cycle strobe)   | total_penalty_o, infeasible_o, words_seen_o
//
// a word is taken when start_i is high while idle; words not marked last are taken back to back
// the word marked last starts the backward search: init, then per start position a row step;
// per end position read, accumulate and, if it fits, square, cube, add, compare; then a closing step
// the search runs on one length read port and one cost read port of the stores
// busy_o stays high for the search; done_o is registered from the closing step and rises as busy_o falls
// reset clears the word count, the control state and sets line_width to 80
module min_raggedness_line_break_top #(
  parameter int unsigned MAX_WORDS = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mrlb_pkg::LEN_W-1:0]  word_length_i,
  input  logic                        last_word_i,
  output logic                        busy_o,
  input  logic                        line_width_we_i,
  input  logic [mrlb_pkg::LEN_W-1:0]  line_width_i,
  output logic                        done_o,
  output logic [mrlb_pkg::PEN_W-1:0]  total_penalty_o,
  output logic                        infeasible_o,
  output logic [mrlb_pkg::SEEN_W-1:0] words_seen_o
);

  mrlb_pkg::mrlb_cmd_t  cmd;
  mrlb_pkg::mrlb_stat_t stat;

  // sequencer
  mrlb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .last_word_i (last_word_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy_o      (busy_o)
  );

  // stores, cost arithmetic and result registers
  mrlb_dp #(
    .MAX_WORDS (MAX_WORDS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .word_length_i   (word_length_i),
    .line_width_we_i (line_width_we_i),
    .line_width_i    (line_width_i),
    .done_o          (done_o),
    .total_penalty_o (total_penalty_o),
    .infeasible_o    (infeasible_o),
    .words_seen_o    (words_seen_o)
  );

endmodule

[src/mrlb_ctrl.sv]
module mrlb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 last_word_i,
  input  mrlb_pkg::mrlb_stat_t stat_i,
  output mrlb_pkg::mrlb_cmd_t  cmd_o,
  output logic                 busy_o
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_INIT = 10'b0000000010,
    S_ROW  = 10'b0000000100,
    S_RD   = 10'b0000001000,
    S_ACC  = 10'b0000010000,
    S_SQ   = 10'b0000100000,
    S_CUBE = 10'b0001000000,
    S_ADD  = 10'b0010000000,
    S_CMP  = 10'b0100000000,
    S_END  = 10'b1000000000
  } mrlb_state_e;

  mrlb_state_e state_q, state_d;

  // next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (last_word_i) state_d = S_INIT;
        end
      end
      S_INIT: begin
        cmd_o.init_i = 1'b1;
        state_d      = S_ROW;
      end
      S_ROW: begin
        cmd_o.row_init = 1'b1;
        state_d        = S_RD;
      end
      S_RD: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = stat_i.brk ? S_END : S_SQ;
      end
      S_SQ: begin
        cmd_o.sq = 1'b1;
        state_d  = S_CUBE;
      end
      S_CUBE: begin
        cmd_o.cube = 1'b1;
        state_d    = S_ADD;
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = stat_i.j_last ? S_END : S_RD;
      end
      S_END: begin
        cmd_o.fin = 1'b1;
        state_d   = (!stat_i.any || stat_i.i_zero) ? S_IDLE : S_ROW;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

[src/mrlb_dp.sv]
module mrlb_dp #(
  parameter int unsigned MAX_WORDS = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mrlb_pkg::mrlb_cmd_t               cmd_i,
  output mrlb_pkg::mrlb_stat_t              stat_o,
  input  logic [mrlb_pkg::LEN_W-1:0]        word_length_i,
  input  logic                              line_width_we_i,
  input  logic [mrlb_pkg::LEN_W-1:0]        line_width_i,
  output logic                              done_o,
  output logic [mrlb_pkg::PEN_W-1:0]        total_penalty_o,
  output logic                              infeasible_o,
  output logic [mrlb_pkg::SEEN_W-1:0]       words_seen_o
);

  localparam int unsigned AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned CW = $clog2(MAX_WORDS + 1);
  localparam int unsigned LW = mrlb_pkg::LEN_W;
  localparam int unsigned PW = mrlb_pkg::PEN_W;
  localparam int unsigned UW = mrlb_pkg::USED_W;

  // word lengths and best suffix costs
  logic [LW-1:0] len_mem  [MAX_WORDS];
  logic [PW-1:0] cost_mem [MAX_WORDS];
  logic [LW-1:0] len_rd_q;
  logic [PW-1:0] cost_rd_q;

  logic [LW-1:0]               width_q;
  logic [CW-1:0]               count_q;
  logic                        done_q;
  logic                        any_q;
  logic [AW-1:0]               i_q, j_q;
  logic [UW-1:0]               used_q;
  logic [LW-1:0]               slack_q;
  logic [mrlb_pkg::SQ_W-1:0]   sq_q;
  logic [mrlb_pkg::CUBE_W-1:0] cube_q;
  logic [PW-1:0]               cost_q, best_q;
  logic [PW-1:0]               total_q;
  logic                        infeasible_q;
  logic [mrlb_pkg::SEEN_W-1:0] seen_q;

  logic          full;
  logic          j_first, j_last, i_zero, brk, emit;
  logic [CW-1:0] cnt_m1;
  logic [UW-1:0] used_sum;
  logic [AW-1:0] cost_addr;
  logic [PW:0]   sum_wide;
  logic [PW-1:0] cost_sat, cost_new;

  // position and fit status
  always_comb begin
    full      = (count_q == CW'(MAX_WORDS));
    cnt_m1    = count_q - CW'(1);
    j_first   = (j_q == i_q);
    j_last    = ((CW'(j_q) + CW'(1)) == count_q);
    i_zero    = (i_q == '0);
    used_sum  = used_q + UW'(len_rd_q) + {{(UW-1){1'b0}}, ~j_first};
    brk       = (used_sum > UW'(width_q));
    cost_addr = j_last ? j_q : (j_q + AW'(1));
    emit      = cmd_i.fin && (!any_q || i_zero);
  end

  // line cost: cubed slack plus saturated suffix cost, zero for the final line
  always_comb begin
    sum_wide = {1'b0, cost_rd_q} + (PW + 1)'(cube_q);
    cost_sat = sum_wide[PW] ? mrlb_pkg::PENALTY_MAX : sum_wide[PW-1:0];
    cost_new = j_last ? '0 : cost_sat;
  end

  assign stat_o.brk    = brk;
  assign stat_o.j_last = j_last;
  assign stat_o.i_zero = i_zero;
  assign stat_o.any    = any_q;

  // length store: write on load, registered read at end position
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      len_mem[count_q[AW-1:0]] <= word_length_i;
    end
    len_rd_q <= len_mem[j_q];
  end

  // suffix cost store: write when a start position closes with a fitting line
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin && any_q) begin
      cost_mem[i_q] <= best_q;
    end
    cost_rd_q <= cost_mem[cost_addr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= mrlb_pkg::LINE_WIDTH_RST;
      count_q <= '0;
      done_q  <= 1'b0;
      any_q   <= 1'b0;
    end else begin
      if (line_width_we_i) width_q <= line_width_i;
      if (emit) begin
        count_q <= '0;
      end else if (cmd_i.load && !full) begin
        count_q <= count_q + CW'(1);
      end
      done_q <= emit;
      if (cmd_i.row_init) begin
        any_q <= 1'b0;
      end else if (cmd_i.cmp) begin
        any_q <= 1'b1;
      end
    end
  end

  // search datapath
  always_ff @(posedge clk_i) begin
    if (cmd_i.init_i) i_q <= cnt_m1[AW-1:0];
    if (cmd_i.fin && any_q && !i_zero) i_q <= i_q - AW'(1);
    if (cmd_i.row_init) begin
      j_q    <= i_q;
      used_q <= '0;
      best_q <= mrlb_pkg::PENALTY_MAX;
    end
    if (cmd_i.acc) begin
      used_q  <= used_sum;
      slack_q <= width_q - used_sum[LW-1:0];
    end
    if (cmd_i.sq)   sq_q   <= mrlb_pkg::SQ_W'(slack_q) * mrlb_pkg::SQ_W'(slack_q);
    if (cmd_i.cube) cube_q <= mrlb_pkg::CUBE_W'(sq_q) * mrlb_pkg::CUBE_W'(slack_q);
    if (cmd_i.add)  cost_q <= cost_new;
    if (cmd_i.cmp) begin
      if (!any_q || (cost_q < best_q)) best_q <= cost_q;
      if (!j_last) j_q <= j_q + AW'(1);
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (emit) begin
      total_q      <= any_q ? best_q : '0;
      infeasible_q <= !any_q;
      seen_q       <= mrlb_pkg::SEEN_W'(count_q);
    end
  end

  assign done_o          = done_q;
  assign total_penalty_o = total_q;
  assign infeasible_o    = infeasible_q;
  assign words_seen_o    = seen_q;

endmodule

[src/mrlb_checker.sv]
module mrlb_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        last_word_i,
  input logic                        busy_o,
  input logic                        done_o,
  input logic [mrlb_pkg::PEN_W-1:0]  total_penalty_o,
  input logic                        infeasible_o
);

  // the final word of a text starts the search
  a_last_starts_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && last_word_i |=> busy_o)
    else $error("search did not start after final word");

  // other words are stored without a result
  a_word_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && !last_word_i |=> !busy_o && !done_o)
    else $error("plain word caused busy or result");

  // a result closes a search
  a_done_after_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o) && !busy_o)
    else $error("result without a finished search");

  // infeasible text reports zero penalty
  a_infeasible_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && infeasible_o |-> total_penalty_o == '0)
    else $error("infeasible result with nonzero penalty");

  // the result strobe falls straight after it rises
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

endmodule

bind min_raggedness_line_break_top mrlb_checker u_mrlb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .last_word_i     (last_word_i),
  .busy_o          (busy_o),
  .done_o          (done_o),
  .total_penalty_o (total_penalty_o),
  .infeasible_o    (infeasible_o)
);
